// File: rtl/core/u8pe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8pe_pkg
// Shared types, constants and helpers for the UTF-8 percent encoder.
// ----------------------------------------------------------------------------
package u8pe_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned CHAR_W = 7;

    localparam logic [CP_W-1:0] CP_2BYTE_MIN = 21'h00_0080;
    localparam logic [CP_W-1:0] CP_3BYTE_MIN = 21'h00_0800;
    localparam logic [CP_W-1:0] CP_4BYTE_MIN = 21'h01_0000;
    localparam logic [CP_W-1:0] CP_LIMIT     = 21'h11_0000;

    localparam logic [7:0] LEAD_2 = 8'hC0;
    localparam logic [7:0] LEAD_3 = 8'hE0;
    localparam logic [7:0] LEAD_4 = 8'hF0;
    localparam logic [7:0] CONT   = 8'h80;

    localparam logic [CHAR_W-1:0] CH_PERCENT = 7'h25;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CH_ALPHA   = 7'h37;  // 'A' - 10

    // Position within one escaped byte: '%', high digit, low digit
    typedef enum logic [1:0] {
        PH_PCT = 2'd0,
        PH_HI  = 2'd1,
        PH_LO  = 2'd2
    } phase_t;

    // Encoded code point, ready for serialization
    typedef struct packed {
        logic            keep;      // something to emit
        logic            ascii;     // single passthrough char in bytes[0]
        logic [1:0]      last_byte; // index of final byte
        logic [3:0][7:0] bytes;     // bytes[0] goes out first
    } enc_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] wide;
        wide = {3'b000, nib};
        if (nib < 4'd10)
        begin
            hex_char = CH_ZERO + wide;
        end
        else
        begin
            hex_char = CH_ALPHA + wide;
        end
    endfunction

endpackage

// File: rtl/core/utf8_percent_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_percent_encoder
// Code point in, percent-encoded UTF-8 character stream out.
// ----------------------------------------------------------------------------
// Each input word is one 21-bit code point. Below 0x80 it comes out as one
// character with last set. From 0x80 to 0x10FFFF it is UTF-8 encoded into
// 2, 3 or 4 bytes and each byte goes out as '%' plus two uppercase hex
// digits, so 6, 9 or 12 output words; last marks the final one. Code
// points of 0x110000 and above are accepted and dropped with no output.
// Surrogates are encoded like any other value. Throughput is set by the
// output port, one character per cycle while out_stall is low. The next
// input word is taken in the same cycle the current item's final
// character moves into the output register, so passthrough characters
// also stream at that rate. An accepted word goes into the item register
// before its first character moves into the output register.
// ----------------------------------------------------------------------------
module utf8_percent_encoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [u8pe_pkg::CP_W-1:0]   code_point,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [u8pe_pkg::CHAR_W-1:0] out_char,
    output logic                        last
);
    import u8pe_pkg::*;

    // encoded form of the incoming code point (pure logic)
    enc_t enc;

    u8pe_encode u_encode (
        .code_point (code_point),
        .enc        (enc)
    );

    // item register + char sequencer + output register
    u8pe_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .enc       (enc),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last      (last)
    );

endmodule

// File: rtl/core/u8pe_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8pe_encode
// Splits a code point into its UTF-8 byte sequence.
// ----------------------------------------------------------------------------
module u8pe_encode (
    input  logic [u8pe_pkg::CP_W-1:0] code_point,
    output u8pe_pkg::enc_t            enc
);
    import u8pe_pkg::*;

    always_comb
    begin
        enc = '0;
        if (code_point < CP_2BYTE_MIN)
        begin
            enc.keep      = 1'b1;
            enc.ascii     = 1'b1;
            enc.last_byte = 2'd0;
            enc.bytes[0]  = {1'b0, code_point[6:0]};
        end
        else if (code_point < CP_3BYTE_MIN)
        begin
            enc.keep      = 1'b1;
            enc.last_byte = 2'd1;
            enc.bytes[0]  = LEAD_2 | {3'b000, code_point[10:6]};
            enc.bytes[1]  = CONT | {2'b00, code_point[5:0]};
        end
        else if (code_point < CP_4BYTE_MIN)
        begin
            enc.keep      = 1'b1;
            enc.last_byte = 2'd2;
            enc.bytes[0]  = LEAD_3 | {4'b0000, code_point[15:12]};
            enc.bytes[1]  = CONT | {2'b00, code_point[11:6]};
            enc.bytes[2]  = CONT | {2'b00, code_point[5:0]};
        end
        else if (code_point < CP_LIMIT)
        begin
            enc.keep      = 1'b1;
            enc.last_byte = 2'd3;
            enc.bytes[0]  = LEAD_4 | {5'b00000, code_point[20:18]};
            enc.bytes[1]  = CONT | {2'b00, code_point[17:12]};
            enc.bytes[2]  = CONT | {2'b00, code_point[11:6]};
            enc.bytes[3]  = CONT | {2'b00, code_point[5:0]};
        end
    end

endmodule

// File: rtl/core/u8pe_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8pe_serializer
// Holds one encoded code point and emits it one char per cycle while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module u8pe_serializer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  u8pe_pkg::enc_t              enc,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [u8pe_pkg::CHAR_W-1:0] out_char,
    output logic                        last
);
    import u8pe_pkg::*;

    logic            item_valid_reg, item_valid_next;
    logic            item_ascii_reg, item_ascii_next;
    logic [1:0]      item_lastb_reg, item_lastb_next;
    logic [3:0][7:0] item_bytes_reg, item_bytes_next;
    logic [1:0]      sel_reg, sel_next;
    phase_t          phase_reg, phase_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic              out_adv;
    logic              emit;
    logic              item_done;
    logic              accept;
    logic [7:0]        cur_byte;
    logic [CHAR_W-1:0] cur_char;

    always_comb
    begin
        out_adv   = !out_valid_reg || !out_stall;
        emit      = item_valid_reg && out_adv;
        item_done = emit && (item_ascii_reg ||
                             (phase_reg == PH_LO && sel_reg == item_lastb_reg));
        in_stall  = item_valid_reg && !item_done;
        accept    = in_valid && !in_stall;
        cur_byte  = item_bytes_reg[sel_reg];
    end

    always_comb
    begin
        case (phase_reg)
            PH_PCT:  cur_char = item_ascii_reg ? cur_byte[6:0] : CH_PERCENT;
            PH_HI:   cur_char = hex_char(cur_byte[7:4]);
            PH_LO:   cur_char = hex_char(cur_byte[3:0]);
            default: cur_char = CH_PERCENT;
        endcase
    end

    // item register
    always_comb
    begin
        item_valid_next = item_valid_reg;
        item_ascii_next = item_ascii_reg;
        item_lastb_next = item_lastb_reg;
        item_bytes_next = item_bytes_reg;
        sel_next        = sel_reg;
        phase_next      = phase_reg;
        if (emit)
        begin
            case (phase_reg)
                PH_PCT:  phase_next = PH_HI;
                PH_HI:   phase_next = PH_LO;
                PH_LO:
                begin
                    phase_next = PH_PCT;
                    sel_next   = sel_reg + 2'd1;
                end
                default: phase_next = PH_PCT;
            endcase
        end
        if (item_done)
        begin
            item_valid_next = 1'b0;
        end
        if (accept && enc.keep)
        begin
            item_valid_next = 1'b1;
            item_ascii_next = enc.ascii;
            item_lastb_next = enc.last_byte;
            item_bytes_next = enc.bytes;
            sel_next        = 2'd0;
            phase_next      = PH_PCT;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (out_adv)
        begin
            out_valid_next = emit;
            out_char_next  = cur_char;
            out_last_next  = item_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            sel_reg        <= 2'd0;
            phase_reg      <= PH_PCT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            sel_reg        <= sel_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_ascii_reg <= item_ascii_next;
        item_lastb_reg <= item_lastb_next;
        item_bytes_reg <= item_bytes_next;
        out_char_reg   <= out_char_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = out_last_reg;

    // byte pointer never runs past the final byte
    a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> (sel_reg <= item_lastb_reg))
        else $error("byte select past final byte");

    // passthrough item sits at its first position
    a_ascii_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && item_ascii_reg) |-> (sel_reg == 2'd0 && phase_reg == PH_PCT))
        else $error("passthrough item left first position");

    // escape start produces a non-final percent sign
    a_pct_out: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !item_ascii_reg && phase_reg == PH_PCT)
        |=> (out_valid_reg && out_char_reg == CH_PERCENT && !out_last_reg))
        else $error("escape did not start with percent");

    // input only taken once the held item is finishing
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_valid_reg) |-> item_done)
        else $error("item register overrun");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 percent encoder.
// ----------------------------------------------------------------------------
// Code points go in through a bursty sender. A local encoder model expands
// each accepted word into the characters it should produce, and every
// character taken from the output is checked against the oldest of those.
// A short table of boundary code points runs first, with known escapes
// typed in where they are obvious. A long run of random code points of
// every length class follows, surrogates and dropped values among them.
// The receiver stalls in changing patterns and once holds off long enough
// to back the encoder up into its input.
// ----------------------------------------------------------------------------
module tb_top;

    import u8pe_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_WORDS  = 260;
    localparam int DRAIN_CYCLES  = 30;   // well past one 12-character item
    localparam int HOLD_AT_WORD  = 120;  // long receiver hold-off starts here
    localparam int HOLD_CYCLES   = 300;
    localparam int DIRECTED_ROWS = 23;

    // One expected output character
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              fin;
    } enc_char_t;

    // One input word; typed rows carry their expected text, right-justified,
    // and bypass the encoder model
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            typed;
        logic [95:0]     text;
    } stim_word_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_EVERY_THIRD,
        STALL_HEAVY
    } stall_mode_t;

    typedef enum int {
        CLS_ASCII,
        CLS_TWO,
        CLS_THREE,
        CLS_FOUR,
        CLS_DROP,
        CLS_RAW
    } cp_class_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [CP_W-1:0]   code_point = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CHAR_W-1:0] out_char;
    logic              last;

    stim_word_t  offer = '0;      // word currently on the input port
    stim_word_t  stim_q[$];
    stim_word_t  directed_tab [0:DIRECTED_ROWS-1];
    enc_char_t   char_q[$];       // characters still owed by the encoder

    bit          word_taken = 1'b0;  // sampled mid-cycle, acted on at the edge
    bit          stim_done  = 1'b0;
    int          cycle_count = 0;
    int          fail_count  = 0;
    int          words_in    = 0;
    int          chars_out   = 0;
    int          n_ascii = 0, n_two = 0, n_three = 0, n_four = 0, n_drop = 0, n_surr = 0;

    utf8_percent_encoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_point (code_point),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] nibble_to_hex(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return 7'h30 + {3'b000, nib};
        end
        return 7'h41 + {3'b000, nib} - 7'd10;
    endfunction

    // '%' and two hex digits; only the low digit can carry the final mark
    function automatic void push_escaped_byte(input logic [7:0] b, input logic fin);
        char_q.push_back('{ch: CH_PERCENT, fin: 1'b0});
        char_q.push_back('{ch: nibble_to_hex(b[7:4]), fin: 1'b0});
        char_q.push_back('{ch: nibble_to_hex(b[3:0]), fin: fin});
    endfunction

    function automatic void encode_code_point(input logic [CP_W-1:0] cp);
        if (cp < 21'h00_0080)
        begin
            char_q.push_back('{ch: cp[6:0], fin: 1'b1});
        end
        else if (cp < 21'h00_0800)
        begin
            push_escaped_byte({3'b110, cp[10:6]}, 1'b0);
            push_escaped_byte({2'b10, cp[5:0]}, 1'b1);
        end
        else if (cp < 21'h01_0000)
        begin
            push_escaped_byte({4'b1110, cp[15:12]}, 1'b0);
            push_escaped_byte({2'b10, cp[11:6]}, 1'b0);
            push_escaped_byte({2'b10, cp[5:0]}, 1'b1);
        end
        else if (cp < 21'h11_0000)
        begin
            push_escaped_byte({5'b11110, cp[20:18]}, 1'b0);
            push_escaped_byte({2'b10, cp[17:12]}, 1'b0);
            push_escaped_byte({2'b10, cp[11:6]}, 1'b0);
            push_escaped_byte({2'b10, cp[5:0]}, 1'b1);
        end
        // beyond Unicode: nothing owed
    endfunction

    // Queue a typed-in expectation; zero bytes on the left are padding
    function automatic void push_typed_text(input logic [95:0] text);
        int remaining;
        logic [7:0] c;
        remaining = 0;
        for (int i = 0; i < 12; i++)
        begin
            if (text[i*8 +: 8] != 8'h00)
            begin
                remaining++;
            end
        end
        for (int i = 11; i >= 0; i--)
        begin
            c = text[i*8 +: 8];
            if (c != 8'h00)
            begin
                remaining--;
                char_q.push_back('{ch: c[6:0], fin: (remaining == 0)});
            end
        end
    endfunction

    function automatic logic [CP_W-1:0] random_code_point();
        cp_class_t  cls;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)      cls = CLS_ASCII;
        else if (pick < 40) cls = CLS_TWO;
        else if (pick < 60) cls = CLS_THREE;
        else if (pick < 80) cls = CLS_FOUR;
        else if (pick < 88) cls = CLS_DROP;
        else                cls = CLS_RAW;
        case (cls)
            CLS_ASCII: return CP_W'($urandom_range(21'h00_0000, 21'h00_007F));
            CLS_TWO:   return CP_W'($urandom_range(21'h00_0080, 21'h00_07FF));
            CLS_THREE:
            begin
                // a quarter of the three-byte picks are drawn from the surrogate range
                if ($urandom_range(0, 3) == 0)
                begin
                    return CP_W'($urandom_range(21'h00_D800, 21'h00_DFFF));
                end
                return CP_W'($urandom_range(21'h00_0800, 21'h00_FFFF));
            end
            CLS_FOUR:  return CP_W'($urandom_range(21'h01_0000, 21'h10_FFFF));
            CLS_DROP:  return CP_W'($urandom_range(21'h11_0000, 21'h1F_FFFF));
            default:   return CP_W'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Mid-cycle monitor: handshakes seen here complete at the next rising
    // edge, and all ports are settled by now, so nothing races the DUT.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : monitor
        enc_char_t want;
        if (!rst_n)
        begin
            word_taken = 1'b0;
        end
        else
        begin
            word_taken = in_valid && !in_stall;
            if (word_taken)
            begin
                words_in++;
                if (offer.cp < 21'h00_0080)      n_ascii++;
                else if (offer.cp < 21'h00_0800) n_two++;
                else if (offer.cp < 21'h01_0000) n_three++;
                else if (offer.cp < 21'h11_0000) n_four++;
                else                             n_drop++;
                if (offer.cp >= 21'h00_D800 && offer.cp <= 21'h00_DFFF)
                begin
                    n_surr++;
                end
                if (offer.typed)
                begin
                    push_typed_text(offer.text);
                end
                else
                begin
                    encode_code_point(offer.cp);
                end
            end
            // push first, check second: a word's characters are queued before any of them is checked
            if (out_valid && !out_stall)
            begin
                chars_out++;
                if (char_q.size() == 0)
                begin
                    fail_count++;
                    $display("[%0t] unexpected word: expected none, actual char %h last %b",
                             $time, out_char, last);
                end
                else
                begin
                    want = char_q.pop_front();
                    if (out_char !== want.ch)
                    begin
                        fail_count++;
                        $display("[%0t] out_char mismatch: expected %h, actual %h",
                                 $time, want.ch, out_char);
                    end
                    if (last !== want.fin)
                    begin
                        fail_count++;
                        $display("[%0t] last mismatch: expected %b, actual %b",
                                 $time, want.fin, last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall mode changes at random intervals; one long hold-off
    // once enough words have gone in, to back the encoder up.
    // ------------------------------------------------------------------------
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;

    always @(posedge clk)
    begin
        if (!hold_done && words_in >= HOLD_AT_WORD)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(8, 80);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:        out_stall <= 1'b0;
                STALL_LIGHT:       out_stall <= ($urandom_range(0, 99) < 30);
                STALL_EVERY_THIRD: out_stall <= ((cycle_count % 3) == 0);
                default:           out_stall <= ($urandom_range(0, 99) < 75);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles, %0d chars still owed",
                     $time, cycle_count, char_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender: bursts of back-to-back words, valid held across each burst,
    // random gaps between bursts, and one pause midway until all is drained.
    // ------------------------------------------------------------------------
    initial
    begin : sender
        int i;
        int burst_left;
        int pause_at;

        directed_tab = '{
            '{21'h00_0000, 1'b0, 96'h0},
            '{21'h00_007F, 1'b0, 96'h0},
            '{21'h00_0041, 1'b1, "A"},
            '{21'h00_0025, 1'b1, "%"},               // percent itself passes through
            '{21'h00_0080, 1'b1, "%C2%80"},
            '{21'h00_07FF, 1'b1, "%DF%BF"},
            '{21'h00_0800, 1'b1, "%E0%A0%80"},
            '{21'h00_FFFF, 1'b1, "%EF%BF%BF"},
            '{21'h00_D800, 1'b1, "%ED%A0%80"},       // surrogates, encoded like any other value
            '{21'h00_DFFF, 1'b1, "%ED%BF%BF"},
            '{21'h01_0000, 1'b1, "%F0%90%80%80"},
            '{21'h10_FFFF, 1'b1, "%F4%8F%BF%BF"},
            '{21'h11_0000, 1'b1, 96'h0},             // beyond Unicode: dropped
            '{21'h1F_FFFF, 1'b1, 96'h0},
            '{21'h00_007E, 1'b0, 96'h0},
            '{21'h00_00AB, 1'b0, 96'h0},
            '{21'h00_ABCD, 1'b0, 96'h0},
            '{21'h0A_AAAA, 1'b0, 96'h0},
            '{21'h05_5555, 1'b0, 96'h0},
            '{21'h00_D7FF, 1'b0, 96'h0},
            '{21'h00_E000, 1'b0, 96'h0},
            '{21'h10_FFFE, 1'b0, 96'h0},
            '{21'h00_0001, 1'b0, 96'h0}
        };
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            stim_q.push_back(directed_tab[r]);
        end
        for (int r = 0; r < RANDOM_WORDS; r++)
        begin
            stim_q.push_back('{cp: random_code_point(), typed: 1'b0, text: 96'h0});
        end
        pause_at = DIRECTED_ROWS + RANDOM_WORDS / 2;

        wait (rst_n === 1'b1);
        i = 0;
        while (i < stim_q.size())
        begin
            burst_left = $urandom_range(1, 24);
            @(posedge clk);
            forever
            begin
                in_valid   <= 1'b1;
                code_point <= stim_q[i].cp;
                offer      <= stim_q[i];
                do
                    @(posedge clk);
                while (!word_taken);
                i++;
                burst_left--;
                if (burst_left == 0 || i == stim_q.size() || i == pause_at)
                begin
                    break;
                end
            end
            in_valid <= 1'b0;
            if (i == pause_at)
            begin
                while (char_q.size() != 0)
                begin
                    @(posedge clk);
                end
                repeat (DRAIN_CYCLES) @(posedge clk);
            end
            else
            begin
                repeat ($urandom_range(0, 12)) @(posedge clk);
            end
        end
        stim_done = 1'b1;
    end

    // ------------------------------------------------------------------------
    // Reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin : run_ctl
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        while (char_q.size() != 0)
        begin
            @(posedge clk);
        end
        // a dropped word at the end owes nothing; give stray output time to show
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d words in / %0d chars out: ascii %0d, 2-byte %0d, 3-byte %0d",
                 words_in, chars_out, n_ascii, n_two, n_three);
        $display("  4-byte %0d, dropped %0d, surrogates %0d, %0d errors, %0d cycles",
                 n_four, n_drop, n_surr, fail_count, cycle_count);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
